### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SOSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SOSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sosc_pkg.sv
// ---------------------------------------------------------------------------
// sosc_pkg
// Shared widths, register map, status structs and the CORDIC arctangent
// table of the sine oscillator.
// ---------------------------------------------------------------------------
`default_nettype none

package sosc_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int SINE_BITS    = 16;

    localparam int FREQ_W       = 24;
    localparam int AMP_W        = 16;
    localparam int RATE_W       = 18;
    localparam int CFG_W        = 24;
    localparam int CFG_IDX_W    = 3;

    localparam int DIVISOR_W    = RATE_W + 8;
    localparam int PROD_W       = FREQ_W + COUNT_WIDTH;
    localparam int DIV_STEPS    = PROD_W + SINE_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    localparam int PHASE_W      = 32;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_STEPS = 30;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int SINE_W       = 32;
    localparam int CORDIC_GAIN  = 652032874;

    localparam int Q_W          = SINE_BITS + 1;
    localparam int MPROD_W      = AMP_W + Q_W;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_AMP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_EXT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_EXT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd4;

    localparam logic [FREQ_W-1:0]        BASE_FREQ_RST   = 24'd112640;
    localparam logic signed [AMP_W-1:0]  BASE_AMP_RST    = 16'sd16384;
    localparam logic [RATE_W-1:0]        SAMPLE_RATE_RST = 18'd48000;

    typedef struct packed {
        logic                 done;
        logic                 wrap;
        logic [SINE_BITS-1:0] quot;
    } div_res_t;

    typedef struct packed {
        logic                     done;
        logic signed [SINE_W-1:0] sine;
    } cordic_res_t;

    // arctangent of 2^-i in 1/2^32 turns
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return $signed({1'b0, v});
    endfunction

endpackage

`default_nettype wire

### rtl/sine_oscillator_counter_phase_top.sv
// ---------------------------------------------------------------------------
// sine_oscillator_counter_phase_top
// Sine oscillator with a step counter: amp * sin(2*pi*f*n/(256*rate)) per tick.
// ---------------------------------------------------------------------------
// Each input transfer is one sample tick and yields one output transfer.
// An item is finished before the next one is taken: a 72-step serial long
// division gives (f*n mod 256*rate) as a phase fraction, a 30-step CORDIC
// turns it into a sine, and the S_SCALE and S_OUT states scale, round and
// saturate. in_stall is high for the whole computation. The finished sample
// sits in an output register, so the next tick is accepted while it waits.
// The counter n restarts at 1 once f*n >= 256*rate. Configuration must be
// written only while the block is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sine_oscillator_counter_phase_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [sosc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sosc_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [sosc_pkg::FREQ_W-1:0]       freq_control,
    input  wire logic signed [sosc_pkg::AMP_W-1:0] amp_control,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic signed [sosc_pkg::AMP_W-1:0] sample_out
);
    import sosc_pkg::*;

    localparam logic signed [MPROD_W:0] SAT_HI   = (MPROD_W + 1)'(2 ** (AMP_W - 1) - 1);
    localparam logic signed [MPROD_W:0] SAT_LO   = -SAT_HI - (MPROD_W + 1)'(1);
    localparam logic signed [MPROD_W:0] OUT_HALF = (MPROD_W + 1)'(1) << (SINE_BITS - 3);
    localparam logic signed [SINE_W:0]  Q_HALF   = (SINE_W + 1)'(1) << (30 - SINE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_CORDIC,
        S_SCALE,
        S_OUT
    } state_t;

    state_t                    state_reg, state_next;

    logic [FREQ_W-1:0]         base_freq_reg, base_freq_next;
    logic signed [AMP_W-1:0]   base_amp_reg, base_amp_next;
    logic                      freq_ext_reg, freq_ext_next;
    logic                      amp_ext_reg, amp_ext_next;
    logic [RATE_W-1:0]         rate_reg, rate_next;

    logic [COUNT_WIDTH-1:0]    step_count_reg, step_count_next;
    logic [FREQ_W-1:0]         f_reg, f_next;
    logic signed [AMP_W-1:0]   amp_reg, amp_next;
    logic [DIVISOR_W-1:0]      d_reg, d_next;
    logic                      wrap_reg, wrap_next;
    logic signed [Q_W-1:0]     q_reg, q_next;
    logic signed [MPROD_W-1:0] mprod_reg, mprod_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [AMP_W-1:0]   sample_reg, sample_next;

    logic                      div_start;
    logic [PROD_W-1:0]         div_dividend;
    div_res_t                  div_res;
    logic                      cordic_start;
    cordic_res_t               cor_res;

    logic signed [SINE_W:0]    s_rnd;
    logic signed [MPROD_W:0]   o_rnd;
    logic signed [MPROD_W:0]   o_full;
    logic signed [AMP_W-1:0]   o_sat;

    assign div_dividend = PROD_W'(f_reg) * PROD_W'(step_count_reg);

    sosc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (d_reg),
        .res      (div_res)
    );

    sosc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .phase ({div_res.quot, {(PHASE_W - SINE_BITS){1'b0}}}),
        .res   (cor_res)
    );

    // Q30 sine to Q1.(SINE_BITS-1), round half up
    assign s_rnd = $signed({cor_res.sine[SINE_W-1], cor_res.sine}) + Q_HALF;

    // amp * q to Q1.15, round half up, saturate
    assign o_rnd  = $signed({mprod_reg[MPROD_W-1], mprod_reg}) + OUT_HALF;
    assign o_full = o_rnd >>> (SINE_BITS - 2);

    always_comb
    begin
        priority if (o_full > SAT_HI)
            o_sat = SAT_HI[AMP_W-1:0];
        else if (o_full < SAT_LO)
            o_sat = SAT_LO[AMP_W-1:0];
        else
            o_sat = o_full[AMP_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        base_freq_next  = base_freq_reg;
        base_amp_next   = base_amp_reg;
        freq_ext_next   = freq_ext_reg;
        amp_ext_next    = amp_ext_reg;
        rate_next       = rate_reg;
        step_count_next = step_count_reg;
        f_next          = f_reg;
        amp_next        = amp_reg;
        d_next          = d_reg;
        wrap_next       = wrap_reg;
        q_next          = q_reg;
        mprod_next      = mprod_reg;
        out_valid_next  = out_valid_reg && out_stall;
        sample_next     = sample_reg;
        div_start       = 1'b0;
        cordic_start    = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BASE_FREQ:   base_freq_next = cfg_data[FREQ_W-1:0];
                CFG_BASE_AMP:    base_amp_next  = $signed(cfg_data[AMP_W-1:0]);
                CFG_FREQ_EXT:    freq_ext_next  = cfg_data[0];
                CFG_AMP_EXT:     amp_ext_next   = cfg_data[0];
                CFG_SAMPLE_RATE: rate_next      = cfg_data[RATE_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    f_next     = freq_ext_reg ? freq_control : base_freq_reg;
                    amp_next   = amp_ext_reg ? amp_control : base_amp_reg;
                    // zero rate is taken as one
                    d_next     = (rate_reg == '0) ? DIVISOR_W'(256) : {rate_reg, 8'h00};
                    state_next = S_START;
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    wrap_next    = div_res.wrap;
                    cordic_start = 1'b1;
                    state_next   = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                if (cor_res.done)
                begin
                    q_next     = $signed(s_rnd[SINE_W-1 -: Q_W]);
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                mprod_next = MPROD_W'(amp_reg) * MPROD_W'(q_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    sample_next     = o_sat;
                    out_valid_next  = 1'b1;
                    step_count_next = wrap_reg ? COUNT_WIDTH'(1)
                                               : step_count_reg + COUNT_WIDTH'(1);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_freq_reg  <= BASE_FREQ_RST;
            base_amp_reg   <= BASE_AMP_RST;
            freq_ext_reg   <= 1'b0;
            amp_ext_reg    <= 1'b0;
            rate_reg       <= SAMPLE_RATE_RST;
            step_count_reg <= '0;
            f_reg          <= '0;
            amp_reg        <= '0;
            d_reg          <= '0;
            wrap_reg       <= 1'b0;
            q_reg          <= '0;
            mprod_reg      <= '0;
            out_valid_reg  <= 1'b0;
            sample_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            base_freq_reg  <= base_freq_next;
            base_amp_reg   <= base_amp_next;
            freq_ext_reg   <= freq_ext_next;
            amp_ext_reg    <= amp_ext_next;
            rate_reg       <= rate_next;
            step_count_reg <= step_count_next;
            f_reg          <= f_next;
            amp_reg        <= amp_next;
            d_reg          <= d_next;
            wrap_reg       <= wrap_next;
            q_reg          <= q_next;
            mprod_reg      <= mprod_next;
            out_valid_reg  <= out_valid_next;
            sample_reg     <= sample_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

    `SOSC_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall)
    `SOSC_ASSERT_NEXT(a_count_step, state_reg == S_OUT && (!out_valid_reg || !out_stall), step_count_reg == COUNT_WIDTH'(1) || step_count_reg == $past(step_count_reg) + COUNT_WIDTH'(1))
    `SOSC_ASSERT_IMP(a_div_done_in_div, div_res.done, state_reg == S_DIV)
    `SOSC_ASSERT_IMP(a_cordic_done_in_cordic, cor_res.done, state_reg == S_CORDIC)

endmodule

`default_nettype wire

### rtl/sosc_div.sv
// ---------------------------------------------------------------------------
// sosc_div
// Serial restoring long division of (f*n) << SINE_BITS by the scaled rate.
// Gives the phase fraction and a flag for f*n >= divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module sosc_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [sosc_pkg::PROD_W-1:0]    dividend,
    input  wire logic [sosc_pkg::DIVISOR_W-1:0] divisor,
    output sosc_pkg::div_res_t                  res
);
    import sosc_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_STEPS-1:0]   num_reg, num_next;
    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [SINE_BITS-1:0]   quot_reg, quot_next;
    logic                   sticky_reg, sticky_next;

    logic [DIVISOR_W:0]     trial;
    logic [DIVISOR_W:0]     diff;
    logic                   ge;

    assign trial = {rem_reg, num_reg[DIV_STEPS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        sticky_next = sticky_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = DIV_CNT_W'(DIV_STEPS);
            num_next    = {dividend, {SINE_BITS{1'b0}}};
            rem_next    = '0;
            quot_next   = '0;
            sticky_next = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next    = {num_reg[DIV_STEPS-2:0], 1'b0};
            rem_next    = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_next   = {quot_reg[SINE_BITS-2:0], ge};
            // integer quotient bits leave the fraction window here
            sticky_next = sticky_reg | quot_reg[SINE_BITS-1];
            cnt_next    = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            num_reg    <= '0;
            rem_reg    <= '0;
            quot_reg   <= '0;
            sticky_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            num_reg    <= num_next;
            rem_reg    <= rem_next;
            quot_reg   <= quot_next;
            sticky_reg <= sticky_next;
        end
    end

    assign res.done = done_reg;
    assign res.wrap = sticky_reg;
    assign res.quot = quot_reg;

endmodule

`default_nettype wire

### rtl/sosc_cordic.sv
// ---------------------------------------------------------------------------
// sosc_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Folds a 32-bit phase to a quarter turn and returns the sine in Q30.
// ---------------------------------------------------------------------------
`default_nettype none

module sosc_cordic (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [sosc_pkg::PHASE_W-1:0] phase,
    output sosc_pkg::cordic_res_t             res
);
    import sosc_pkg::*;

    localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(1) << (PHASE_W - 1);
    localparam logic signed [CORDIC_W-1:0] ONE_Q30   = CORDIC_W'(1) << 30;
    localparam logic signed [CORDIC_W-1:0] GAIN      = CORDIC_W'(CORDIC_GAIN);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;

    logic signed [CORDIC_W-1:0] z_fold;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] angle;

    always_comb
    begin
        unique case (phase[PHASE_W-1 -: 2])
            2'b00:        z_fold = $signed({1'b0, phase});
            2'b01, 2'b10: z_fold = HALF_TURN - $signed({1'b0, phase});
            2'b11:        z_fold = $signed({1'b1, phase});
            default:      z_fold = '0;
        endcase
    end

    assign dx    = y_reg >>> iter_reg;
    assign dy    = x_reg >>> iter_reg;
    assign angle = atan_turn(iter_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = GAIN;
            y_next    = '0;
            z_next    = z_fold;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - angle;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + angle;
            end
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                iter_next = iter_reg + ITER_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    // clamp to +/-1.0
    always_comb
    begin
        res.done = done_reg;
        priority if (y_reg > ONE_Q30)
            res.sine = SINE_W'(ONE_Q30);
        else if (y_reg < -ONE_Q30)
            res.sine = SINE_W'(-ONE_Q30);
        else
            res.sine = y_reg[SINE_W-1:0];
    end

endmodule

`default_nettype wire
